// ===== design/gpd_pkg.sv =====
package gpd_pkg;

  // Configuration register indexes, in the order of the register map.
  typedef enum logic [2:0] {
    REG_KP_X     = 3'd0,
    REG_KD_X     = 3'd1,
    REG_KP_Y     = 3'd2,
    REG_KD_Y     = 3'd3,
    REG_DEADBAND = 3'd4,
    REG_CUTOFF_X = 3'd5,
    REG_CUTOFF_Y = 3'd6,
    REG_STEP_THR = 3'd7
  } gpd_reg_e;

  // Register reset values.
  localparam logic [15:0] KP_RESET       = 16'd1280;
  localparam logic [15:0] KD_RESET       = 16'd768;
  localparam logic [9:0]  DEADBAND_RESET = 10'd4;
  localparam logic [9:0]  CUTOFF_X_RESET = 10'd120;
  localparam logic [9:0]  CUTOFF_Y_RESET = 10'd100;
  localparam logic [15:0] STEP_THR_RESET = 16'd845;

  // Servo compare limits and reset value, stepper step limit.
  localparam logic [10:0] SERVO_MIN   = 11'd1420;
  localparam logic [10:0] SERVO_MAX   = 11'd1500;
  localparam logic [10:0] SERVO_RESET = 11'd1460;
  localparam logic [8:0]  STEP_LIMIT  = 9'd150;

  // Exact reciprocals: floor(n / d) == (n * RECIP) >> SHIFT over the operand range.
  // Proportional terms divide by 90 (X) and 80 (Y) with n < 2**26.
  localparam logic [26:0] RECIP_P_X = 27'd95443718;
  localparam logic [26:0] RECIP_P_Y = 27'd107374183;
  localparam int          P_SHIFT   = 33;
  localparam int          P_QW      = 20;
  // Derivative terms divide by 70 with n < 2**27.
  localparam logic [27:0] RECIP_D   = 28'd245426703;
  localparam int          D_SHIFT   = 34;
  localparam int          D_QW      = 21;

  // Load control for one pipeline register.
  typedef struct packed {
    logic adv;  // the register loads this cycle
    logic vld;  // the item being loaded is a real one
  } gpd_ctl_t;

  // Product magnitudes and signs of one axis.
  typedef struct packed {
    logic        p_neg;
    logic        d_neg;
    logic [25:0] p_mag;
    logic [26:0] d_mag;
  } gpd_prod_t;

  // Truncated quotient magnitudes and signs of one axis.
  typedef struct packed {
    logic             p_neg;
    logic             d_neg;
    logic [P_QW-1:0]  p_q;
    logic [D_QW-1:0]  d_q;
  } gpd_quot_t;

endpackage

// ===== design/gimbal_pd_deadband_drive_top.sv =====
// Two-axis PD drive with deadband and cutoff for a gimbal: each input transaction
// carries measured and target positions for X and Y, and each output transaction
// returns the Q.8 drives of both axes, the new servo compare value (Y axis, clamped
// to 1420..1500), the stepper steps for this tick (X axis, clamped to +/-150) and the
// wrapped 32-bit stepper position. An axis whose absolute error is at or below the
// deadband, or at or above its cutoff, gets zero drive and keeps its last error.
// The block takes one transaction per clock cycle while the output does not stall.
// A result passes through five register ranks in order: the input register, the gain
// products, the reciprocal multipliers that divide by 90, 80 and 70, the drive sums,
// and the output register where the servo and stepper state are updated. Backpressure
// on the output stalls only the stages that are full, so empty stages keep accepting.
// Gains and limits are written through the configuration channel, which is always
// ready; writes are meant for times when no transaction is in flight.
module gimbal_pd_deadband_drive_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input stream.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata from bit 0 up: position_x[15:0], target_x[15:0], position_y[15:0],
  // target_y[15:0], all signed.
  input  logic [63:0]   s_axis_tdata,
  // Output stream.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata from bit 0 up: drive_x[22:0] signed, drive_y[22:0] signed,
  // servo_compare[10:0], stepper_steps[8:0] signed, stepper_position[31:0]
  // signed, then six zero bits.
  output logic [103:0]  m_axis_tdata,
  // Configuration write channel.
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);
  import gpd_pkg::*;

  // Configuration registers.
  logic [15:0] kp_x_q, kd_x_q, kp_y_q, kd_y_q, step_thr_q;
  logic [9:0]  deadband_q, cutoff_x_q, cutoff_y_q;

  // Pipeline occupancy and per-stage ready.
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  // Input register.
  logic signed [15:0] pos_x_q, tgt_x_q, pos_y_q, tgt_y_q;

  gpd_ctl_t  ctl1, ctl4;
  gpd_prod_t prod_x, prod_y;
  gpd_quot_t quot_x, quot_y;

  logic signed [22:0] drive_x, drive_y;
  logic [10:0]        servo_compare;
  logic signed [8:0]  stepper_steps;
  logic signed [31:0] stepper_position;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_x_q     <= KP_RESET;
      kd_x_q     <= KD_RESET;
      kp_y_q     <= KP_RESET;
      kd_y_q     <= KD_RESET;
      deadband_q <= DEADBAND_RESET;
      cutoff_x_q <= CUTOFF_X_RESET;
      cutoff_y_q <= CUTOFF_Y_RESET;
      step_thr_q <= STEP_THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_KP_X:     kp_x_q     <= cfg_data_i;
        REG_KD_X:     kd_x_q     <= cfg_data_i;
        REG_KP_Y:     kp_y_q     <= cfg_data_i;
        REG_KD_Y:     kd_y_q     <= cfg_data_i;
        REG_DEADBAND: deadband_q <= cfg_data_i[9:0];
        REG_CUTOFF_X: cutoff_x_q <= cfg_data_i[9:0];
        REG_CUTOFF_Y: cutoff_y_q <= cfg_data_i[9:0];
        REG_STEP_THR: step_thr_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it loads too.
  always_comb begin
    rdy4 = !v4_q || m_axis_tready;
    rdy3 = !v3_q || rdy4;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    rdy0 = !v0_q || rdy1;
  end

  assign s_axis_tready = rdy0;
  assign m_axis_tvalid = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_q <= s_axis_tvalid;
      end
      if (rdy1) begin
        v1_q <= v0_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      pos_x_q <= s_axis_tdata[15:0];
      tgt_x_q <= s_axis_tdata[31:16];
      pos_y_q <= s_axis_tdata[47:32];
      tgt_y_q <= s_axis_tdata[63:48];
    end
  end

  // The last-error registers move only when a real item enters the product stage.
  assign ctl1.adv = rdy1;
  assign ctl1.vld = v0_q;
  // The servo and stepper state move only when a real item enters the output stage.
  assign ctl4.adv = rdy4;
  assign ctl4.vld = v3_q;

  gpd_axis_front u_front_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl1),
    .position_i (pos_x_q),
    .target_i   (tgt_x_q),
    .kp_i       (kp_x_q),
    .kd_i       (kd_x_q),
    .deadband_i (deadband_q),
    .cutoff_i   (cutoff_x_q),
    .prod_o     (prod_x)
  );

  gpd_axis_front u_front_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl1),
    .position_i (pos_y_q),
    .target_i   (tgt_y_q),
    .kp_i       (kp_y_q),
    .kd_i       (kd_y_q),
    .deadband_i (deadband_q),
    .cutoff_i   (cutoff_y_q),
    .prod_o     (prod_y)
  );

  gpd_div_stage u_div (
    .clk_i    (clk_i),
    .en_i     (rdy2),
    .prod_x_i (prod_x),
    .prod_y_i (prod_y),
    .quot_x_o (quot_x),
    .quot_y_o (quot_y)
  );

  gpd_out_stage u_out (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en3_i              (rdy3),
    .ctl4_i             (ctl4),
    .quot_x_i           (quot_x),
    .quot_y_i           (quot_y),
    .step_thr_i         (step_thr_q),
    .drive_x_o          (drive_x),
    .drive_y_o          (drive_y),
    .servo_compare_o    (servo_compare),
    .stepper_steps_o    (stepper_steps),
    .stepper_position_o (stepper_position)
  );

  assign m_axis_tdata = {6'd0, stepper_position, stepper_steps, servo_compare,
                         drive_y, drive_x};

`ifndef SYNTHESIS
  // With every stage full and the output stalled, no new transaction may enter.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && v1_q && v2_q && v3_q && v4_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline is full and stalled");
`endif

endmodule

// ===== design/gpd_axis_front.sv =====
module gpd_axis_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gpd_pkg::gpd_ctl_t   ctl_i,
  input  logic signed [15:0]  position_i,
  input  logic signed [15:0]  target_i,
  input  logic [15:0]         kp_i,
  input  logic [15:0]         kd_i,
  input  logic [9:0]          deadband_i,
  input  logic [9:0]          cutoff_i,
  output gpd_pkg::gpd_prod_t  prod_o
);
  import gpd_pkg::*;

  logic signed [16:0] err;
  logic [16:0]        err_mag;
  logic               qual;
  logic signed [10:0] err_s;
  logic signed [11:0] diff;
  logic [9:0]         e_mag;
  logic [10:0]        diff_mag;
  logic signed [11:0] last_q, last_d;
  gpd_prod_t          prod_d, prod_q;

  always_comb begin
    err     = {target_i[15], target_i} - {position_i[15], position_i};
    err_mag = err[16] ? 17'(-err) : 17'(err);
    qual    = (err_mag > {7'd0, deadband_i}) && (err_mag < {7'd0, cutoff_i});
    // Inside the window the error fits 11 bits signed.
    err_s    = err[10:0];
    diff     = {err_s[10], err_s} - last_q;
    e_mag    = err_s[10] ? 10'(-err_s) : err_s[9:0];
    diff_mag = diff[11] ? 11'(-diff) : diff[10:0];

    prod_d.p_neg = qual & err_s[10];
    prod_d.d_neg = qual & diff[11];
    prod_d.p_mag = qual ? 26'(kp_i) * 26'(e_mag) : '0;
    prod_d.d_mag = qual ? 27'(kd_i) * 27'(diff_mag) : '0;

    last_d = (ctl_i.adv && ctl_i.vld && qual) ? {err_s[10], err_s} : last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

`ifndef SYNTHESIS
  // The stored error only ever takes values from inside the cutoff window.
  a_last_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_q <= 12'sd1022) && (last_q >= -12'sd1022))
    else $error("last error left the cutoff window");
`endif

endmodule

// ===== design/gpd_div_stage.sv =====
module gpd_div_stage (
  input  logic                clk_i,
  input  logic                en_i,
  input  gpd_pkg::gpd_prod_t  prod_x_i,
  input  gpd_pkg::gpd_prod_t  prod_y_i,
  output gpd_pkg::gpd_quot_t  quot_x_o,
  output gpd_pkg::gpd_quot_t  quot_y_o
);
  import gpd_pkg::*;

  logic [52:0] px_full, py_full;
  logic [54:0] dx_full, dy_full;
  gpd_quot_t   qx_d, qy_d, qx_q, qy_q;

  always_comb begin
    px_full = 53'(prod_x_i.p_mag) * 53'(RECIP_P_X);
    py_full = 53'(prod_y_i.p_mag) * 53'(RECIP_P_Y);
    dx_full = 55'(prod_x_i.d_mag) * 55'(RECIP_D);
    dy_full = 55'(prod_y_i.d_mag) * 55'(RECIP_D);

    qx_d.p_neg = prod_x_i.p_neg;
    qx_d.d_neg = prod_x_i.d_neg;
    qx_d.p_q   = px_full[P_SHIFT +: P_QW];
    qx_d.d_q   = dx_full[D_SHIFT +: D_QW];
    qy_d.p_neg = prod_y_i.p_neg;
    qy_d.d_neg = prod_y_i.d_neg;
    qy_d.p_q   = py_full[P_SHIFT +: P_QW];
    qy_d.d_q   = dy_full[D_SHIFT +: D_QW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qx_q <= qx_d;
      qy_q <= qy_d;
    end
  end

  assign quot_x_o = qx_q;
  assign quot_y_o = qy_q;

endmodule

// ===== design/gpd_out_stage.sv =====
module gpd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en3_i,
  input  gpd_pkg::gpd_ctl_t   ctl4_i,
  input  gpd_pkg::gpd_quot_t  quot_x_i,
  input  gpd_pkg::gpd_quot_t  quot_y_i,
  input  logic [15:0]         step_thr_i,
  output logic signed [22:0]  drive_x_o,
  output logic signed [22:0]  drive_y_o,
  output logic [10:0]         servo_compare_o,
  output logic signed [8:0]   stepper_steps_o,
  output logic signed [31:0]  stepper_position_o
);
  import gpd_pkg::*;

  function automatic logic signed [22:0] signed_term(input logic neg,
                                                     input logic [20:0] mag);
    logic signed [22:0] v;
    v = {2'b00, mag};
    return neg ? -v : v;
  endfunction

  logic signed [22:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [24:0] t_raw, t_adj;
  logic signed [16:0] sv_trunc;
  logic [10:0]        servo_d, servo_q;
  logic               big;
  logic signed [22:0] st_adj, st_raw;
  logic signed [8:0]  steps_d, steps_q;
  logic signed [31:0] accum_d, accum_q;
  logic signed [22:0] drive_x_q, drive_y_q;

  // Drive sums; each term was already truncated toward zero.
  always_comb begin
    dx_d = signed_term(quot_x_i.p_neg, {1'b0, quot_x_i.p_q})
         + signed_term(quot_x_i.d_neg, quot_x_i.d_q);
    dy_d = signed_term(quot_y_i.p_neg, {1'b0, quot_y_i.p_q})
         + signed_term(quot_y_i.d_neg, quot_y_i.d_q);
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // Servo and stepper update from the registered drives.
  always_comb begin
    t_raw    = $signed({6'd0, servo_q, 8'd0}) - {{2{dy_q[22]}}, dy_q};
    t_adj    = t_raw[24] ? t_raw + 25'sd255 : t_raw;
    sv_trunc = t_adj[24:8];
    if (sv_trunc > $signed({6'd0, SERVO_MAX})) begin
      servo_d = SERVO_MAX;
    end else if (sv_trunc < $signed({6'd0, SERVO_MIN})) begin
      servo_d = SERVO_MIN;
    end else begin
      servo_d = sv_trunc[10:0];
    end

    big = dx_q > $signed({7'd0, step_thr_i});
    if (big) begin
      st_adj = dx_q[22] ? dx_q + 23'sd63 : dx_q;
      st_raw = st_adj >>> 6;
    end else begin
      st_adj = dx_q[22] ? dx_q + 23'sd127 : dx_q;
      st_raw = st_adj >>> 7;
    end
    if (st_raw > $signed({14'd0, STEP_LIMIT})) begin
      steps_d = $signed(STEP_LIMIT);
    end else if (st_raw < -$signed({14'd0, STEP_LIMIT})) begin
      steps_d = -$signed(STEP_LIMIT);
    end else begin
      steps_d = st_raw[8:0];
    end

    accum_d = accum_q + {{23{steps_d[8]}}, steps_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_q <= SERVO_RESET;
      accum_q <= '0;
    end else if (ctl4_i.adv && ctl4_i.vld) begin
      servo_q <= servo_d;
      accum_q <= accum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl4_i.adv) begin
      drive_x_q <= dx_q;
      drive_y_q <= dy_q;
      steps_q   <= steps_d;
    end
  end

  assign drive_x_o          = drive_x_q;
  assign drive_y_o          = drive_y_q;
  assign servo_compare_o    = servo_q;
  assign stepper_steps_o    = steps_q;
  assign stepper_position_o = accum_q;

`ifndef SYNTHESIS
  // The servo state never leaves its clamp range.
  a_servo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (servo_q >= SERVO_MIN) && (servo_q <= SERVO_MAX))
    else $error("servo value outside clamp range");
  // A loaded result carries a clamped step count.
  a_steps_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl4_i.adv && ctl4_i.vld) |=>
      ((steps_q <= 9'sd150) && (steps_q >= -9'sd150)))
    else $error("stepper steps outside clamp range");
`endif

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import gpd_pkg::*;

  // Eight register phases of about 236 ticks each give roughly 1900 ticks in total.
  localparam int NUM_PHASES      = 8;
  localparam int TICKS_PER_PHASE = 236;
  // A short settle after the drain covers anything still in flight.
  localparam int SETTLE_CYCLES   = 8;
  // This many cycles with no transaction on any channel means the block has hung.
  localparam int WATCHDOG_LIMIT  = 2000;

  // Fields of one output transaction, at the widths of the output port.
  typedef struct {
    logic signed [22:0] drive_x;
    logic signed [22:0] drive_y;
    logic        [10:0] servo_compare;
    logic signed [8:0]  stepper_steps;
    logic signed [31:0] stepper_position;
  } drive_result_t;

  // The scoreboard keeps its own copy of the gains, the limits and the axis state.
  // Each accepted tick is run through that copy, and the result it should produce
  // is queued. Each output transaction is then compared with the oldest entry.
  class drive_scoreboard;
    int kp_x, kd_x, kp_y, kd_y;
    int deadband, cutoff_x, cutoff_y, step_threshold;
    int last_err_x, last_err_y;
    int servo_value;
    logic [31:0] stepper_accum;
    drive_result_t expected_drives[$];
    int errors;

    function new();
      kp_x           = int'(KP_RESET);
      kd_x           = int'(KD_RESET);
      kp_y           = int'(KP_RESET);
      kd_y           = int'(KD_RESET);
      deadband       = int'(DEADBAND_RESET);
      cutoff_x       = int'(CUTOFF_X_RESET);
      cutoff_y       = int'(CUTOFF_Y_RESET);
      step_threshold = int'(STEP_THR_RESET);
      last_err_x     = 0;
      last_err_y     = 0;
      servo_value    = int'(SERVO_RESET);
      stepper_accum  = '0;
      errors         = 0;
    endfunction

    // The 10-bit limits keep only their low bits, as the registers do.
    function void write_reg(gpd_reg_e idx, logic [15:0] val);
      case (idx)
        REG_KP_X:     kp_x = int'(val);
        REG_KD_X:     kd_x = int'(val);
        REG_KP_Y:     kp_y = int'(val);
        REG_KD_Y:     kd_y = int'(val);
        REG_DEADBAND: deadband = int'(val[9:0]);
        REG_CUTOFF_X: cutoff_x = int'(val[9:0]);
        REG_CUTOFF_Y: cutoff_y = int'(val[9:0]);
        REG_STEP_THR: step_threshold = int'(val);
        default: ;
      endcase
    endfunction

    // PD drive of one axis in Q.8. Outside the window between deadband and cutoff
    // the drive is zero and the last error is left alone. Both terms truncate
    // toward zero, which is what signed integer division does here.
    function longint pd_drive(longint err, inout int last_err, input int kp, int kd,
                              int cutoff, longint divisor);
      longint mag;
      longint p_term;
      longint d_term;
      mag = (err < 0) ? -err : err;
      if (mag <= longint'(deadband) || mag >= longint'(cutoff)) return 0;
      p_term   = (longint'(kp) * err) / divisor;
      d_term   = (longint'(kd) * (err - longint'(last_err))) / 70;
      last_err = int'(err);
      return p_term + d_term;
    endfunction

    function void note_tick(logic [63:0] tick);
      longint err_x, err_y, dx, dy, servo_next, steps;
      drive_result_t res;
      err_x = longint'($signed(tick[31:16])) - longint'($signed(tick[15:0]));
      err_y = longint'($signed(tick[63:48])) - longint'($signed(tick[47:32]));
      dy = pd_drive(err_y, last_err_y, kp_y, kd_y, cutoff_y, 80);
      dx = pd_drive(err_x, last_err_x, kp_x, kd_x, cutoff_x, 90);

      // The Y drive pulls the servo compare value, which is clamped every tick.
      servo_next = (longint'(servo_value) * 256 - dy) / 256;
      if (servo_next > longint'(SERVO_MAX)) servo_next = longint'(SERVO_MAX);
      if (servo_next < longint'(SERVO_MIN)) servo_next = longint'(SERVO_MIN);
      servo_value = int'(servo_next);

      // Above the threshold the X drive moves the stepper twice as fast.
      if (dx > longint'(step_threshold)) steps = (dx * 4) / 256;
      else steps = (dx * 2) / 256;
      if (steps > longint'(STEP_LIMIT)) steps = longint'(STEP_LIMIT);
      if (steps < -longint'(STEP_LIMIT)) steps = -longint'(STEP_LIMIT);
      stepper_accum = stepper_accum + steps[31:0];

      res.drive_x          = dx[22:0];
      res.drive_y          = dy[22:0];
      res.servo_compare    = servo_next[10:0];
      res.stepper_steps    = steps[8:0];
      res.stepper_position = stepper_accum;
      expected_drives.push_back(res);
    endfunction

    function void check_drive(logic [103:0] data);
      drive_result_t exp_res;
      drive_result_t act;
      act.drive_x          = $signed(data[22:0]);
      act.drive_y          = $signed(data[45:23]);
      act.servo_compare    = data[56:46];
      act.stepper_steps    = $signed(data[65:57]);
      act.stepper_position = $signed(data[97:66]);
      if (expected_drives.size() == 0) begin
        $error("result transaction with no tick pending");
        errors++;
        return;
      end
      exp_res = expected_drives.pop_front();
      if (act.drive_x !== exp_res.drive_x) begin
        $error("drive_x: expected %0d, got %0d", exp_res.drive_x, act.drive_x);
        errors++;
      end
      if (act.drive_y !== exp_res.drive_y) begin
        $error("drive_y: expected %0d, got %0d", exp_res.drive_y, act.drive_y);
        errors++;
      end
      if (act.servo_compare !== exp_res.servo_compare) begin
        $error("servo_compare: expected %0d, got %0d",
               exp_res.servo_compare, act.servo_compare);
        errors++;
      end
      if (act.stepper_steps !== exp_res.stepper_steps) begin
        $error("stepper_steps: expected %0d, got %0d",
               exp_res.stepper_steps, act.stepper_steps);
        errors++;
      end
      if (act.stepper_position !== exp_res.stepper_position) begin
        $error("stepper_position: expected %0d, got %0d",
               exp_res.stepper_position, act.stepper_position);
        errors++;
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [63:0]   s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [103:0]  m_axis_tdata;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [2:0]    cfg_index;
  logic [15:0]   cfg_data;

  // Percentages of cycles in which the sender holds back or the receiver stalls.
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  drive_scoreboard sb = new();

  gimbal_pd_deadband_drive_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // The receiver decides at each falling edge whether it takes a transaction.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Every accepted result transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_drive(m_axis_tdata);
  end

  // The watchdog restarts whenever any channel completes a transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Packs one tick with the X position in the lowest bits.
  function automatic logic [63:0] pack_tick(int px, int tx, int py, int ty);
    return {16'(ty), 16'(py), 16'(tx), 16'(px)};
  endfunction

  // Offers one tick at a falling edge, after a random number of idle cycles, and
  // holds it until the block accepts it. The prediction is made at the accepting edge.
  task automatic send_tick(logic [63:0] tick);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tick;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(tick);
    @(negedge clk_i);
  endtask

  // Drops the input valid, waits until every predicted result has been checked,
  // then lets the pipeline settle so that a register write cannot overtake a tick
  // still in flight.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] gains [8];
    gpd_reg_e    reg_sel;
    int          px, tx, py, ty, ex, ey;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_KP_X;
    cfg_data      = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    quiet_cycles  = 0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Every phase after the first loads a full set of registers while idle.
      if (phase > 0) begin
        case (phase)
          1: begin
            // Largest gains, no deadband, widest window, highest threshold.
            gains[REG_KP_X] = 16'hFFFF;
            gains[REG_KD_X] = 16'hFFFF;
            gains[REG_KP_Y] = 16'hFFFF;
            gains[REG_KD_Y] = 16'hFFFF;
            gains[REG_DEADBAND] = 16'd0;
            gains[REG_CUTOFF_X] = 16'd1023;
            gains[REG_CUTOFF_Y] = 16'd1023;
            gains[REG_STEP_THR] = 16'hFFFF;
          end
          2: begin
            // Deadband above both cutoffs, so neither axis can ever drive.
            gains[REG_KP_X] = 16'd0;
            gains[REG_KD_X] = 16'd0;
            gains[REG_KP_Y] = 16'd0;
            gains[REG_KD_Y] = 16'd0;
            gains[REG_DEADBAND] = 16'd1023;
            gains[REG_CUTOFF_X] = 16'd0;
            gains[REG_CUTOFF_Y] = 16'd0;
            gains[REG_STEP_THR] = 16'd0;
          end
          3: begin
            // The limits carry set bits above bit 9, which the block must drop.
            gains[REG_KP_X] = 16'($urandom_range(0, 65535));
            gains[REG_KD_X] = 16'($urandom_range(0, 65535));
            gains[REG_KP_Y] = 16'($urandom_range(0, 65535));
            gains[REG_KD_Y] = 16'($urandom_range(0, 65535));
            gains[REG_DEADBAND] = 16'hFC02;
            gains[REG_CUTOFF_X] = 16'hFFFF;
            gains[REG_CUTOFF_Y] = 16'h8300;
            gains[REG_STEP_THR] = 16'd0;
          end
          default: begin
            gains[REG_KP_X] = 16'($urandom_range(0, 65535));
            gains[REG_KD_X] = 16'($urandom_range(0, 65535));
            gains[REG_KP_Y] = 16'($urandom_range(0, 65535));
            gains[REG_KD_Y] = 16'($urandom_range(0, 65535));
            gains[REG_DEADBAND] = 16'($urandom_range(0, 30));
            gains[REG_CUTOFF_X] = 16'($urandom_range(60, 1023));
            gains[REG_CUTOFF_Y] = 16'($urandom_range(60, 1023));
            gains[REG_STEP_THR] = 16'($urandom_range(0, 6000));
          end
        endcase
        reg_sel = reg_sel.first();
        do begin
          cfg_valid <= 1'b1;
          cfg_index <= reg_sel;
          cfg_data  <= gains[reg_sel];
          do @(posedge clk_i); while (!cfg_ready);
          sb.write_reg(reg_sel, gains[reg_sel]);
          @(negedge clk_i);
          reg_sel = reg_sel.next();
        end while (reg_sel != reg_sel.first());
        cfg_valid <= 1'b0;
        @(negedge clk_i);
      end

      // Rotate through no idling, a mostly idle sender, a mostly stalled
      // receiver, and light idling on both sides.
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase

      // Directed ticks under the reset registers: full-scale errors of both
      // signs, zero error, errors right at and just past the deadband, errors just
      // inside and right at each cutoff, and repeated ticks for the derivative term.
      if (phase == 0) begin
        send_tick(pack_tick(-32768, 32767, -32768, 32767));
        send_tick(pack_tick(32767, -32768, 32767, -32768));
        send_tick(pack_tick(0, 0, 0, 0));
        send_tick(pack_tick(100, 104, -50, -46));
        send_tick(pack_tick(100, 96, -50, -54));
        send_tick(pack_tick(100, 105, -50, -45));
        send_tick(pack_tick(100, 95, -50, -55));
        send_tick(pack_tick(0, 119, 0, 99));
        send_tick(pack_tick(0, 120, 0, 100));
        send_tick(pack_tick(0, -119, 0, -99));
        send_tick(pack_tick(0, -120, 0, -100));
        send_tick(pack_tick(-32768, -32649, 32767, 32668));
        send_tick(pack_tick(1000, 1060, 2000, 2050));
        send_tick(pack_tick(1000, 1060, 2000, 2050));
        send_tick(pack_tick(1000, 1007, 2000, 2007));
        send_tick(pack_tick(-7, -100, 5, 90));
        send_tick(pack_tick(-7, -100, 5, 90));
        send_tick(pack_tick(-7, -100, 5, 90));
      end

      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        // Halfway through a phase the sender holds off until the block is empty.
        if (n == TICKS_PER_PHASE / 2) wait_for_drain();
        if ($urandom_range(0, 99) < 15) begin
          // Unrelated positions, which almost always fall outside the window.
          send_tick({$urandom, $urandom});
        end else begin
          // Most ticks place the target near the position, so the error lands
          // around the deadband and the cutoffs and the PD path is exercised.
          ex = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 1100))
                                           : int'($urandom_range(0, 130));
          ey = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 1100))
                                           : int'($urandom_range(0, 130));
          if ($urandom_range(0, 1) != 0) ex = -ex;
          if ($urandom_range(0, 1) != 0) ey = -ey;
          px = int'($urandom_range(0, 65535)) - 32768;
          py = int'($urandom_range(0, 65535)) - 32768;
          tx = px + ex;
          ty = py + ey;
          // Near the ends of the range the error is mirrored to stay in range.
          if (tx > 32767 || tx < -32768) tx = px - ex;
          if (ty > 32767 || ty < -32768) ty = py - ey;
          send_tick(pack_tick(px, tx, py, ty));
        end
      end
      wait_for_drain();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gpd_pkg.sv
design/gpd_axis_front.sv
design/gpd_div_stage.sv
design/gpd_out_stage.sv
design/gimbal_pd_deadband_drive_top.sv
sim/tb_top.sv
